// File: src/pitc_pkg.sv
// ----------------------------------------------------------------------------
// pitc_pkg
// shared types, constants and containment codes for the point-in-triangle
// classifier
// ----------------------------------------------------------------------------
package pitc_pkg;

    // default coordinate width, degrees times 1e7 in two's complement
    localparam int COORD_BITS_DEF = 32;

    // containment codes
    typedef enum logic [2:0] {
        CONT_INSIDE  = 3'd0,
        CONT_EDGE0   = 3'd1,
        CONT_EDGE1   = 3'd2,
        CONT_EDGE2   = 3'd3,
        CONT_VERTEX0 = 3'd4,
        CONT_VERTEX1 = 3'd5,
        CONT_VERTEX2 = 3'd6,
        CONT_OUTSIDE = 3'd7
    } containment_t;

    // sign of one cross product
    typedef struct packed {
        logic neg;
        logic zero;
    } orient_sign_t;

    // load enables for the stages inside the orientation unit
    typedef struct packed {
        logic en_diff;
        logic en_part;
        logic en_prod;
    } pipe_en_t;

endpackage

// File: src/pitc_if.sv
// ----------------------------------------------------------------------------
// pitc channel interfaces
// valid/ready channels for the query transaction and the result transaction
// ----------------------------------------------------------------------------
interface pitc_in_if
    import pitc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex0_x;
    logic signed [COORD_BITS-1:0] vertex0_y;
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;

    modport source (
        output valid,
        input  ready,
        output vertex0_x, vertex0_y, vertex1_x, vertex1_y,
        output vertex2_x, vertex2_y, query_x, query_y
    );

    modport sink (
        input  valid,
        output ready,
        input  vertex0_x, vertex0_y, vertex1_x, vertex1_y,
        input  vertex2_x, vertex2_y, query_x, query_y
    );
endinterface

interface pitc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] containment;

    modport source (
        output valid,
        input  ready,
        output containment
    );

    modport sink (
        input  valid,
        output ready,
        input  containment
    );
endinterface

// File: src/pitc_orient.sv
// ----------------------------------------------------------------------------
// pitc_orient
// pipelined exact orientation test: sign of (b - a) x (c - a)
// ----------------------------------------------------------------------------
module pitc_orient
    import pitc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                         clk,
    input  pipe_en_t                     pipe_en,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output orient_sign_t                 sign
);

    localparam int D = COORD_BITS + 1;   // difference width
    localparam int L = (D + 1) / 2;      // low slice, unsigned
    localparam int H = D - L;            // high slice, signed
    localparam int M = L + 1;            // multiplier operand width
    localparam int W = 2 * M;            // partial product width
    localparam int P = 2 * D;            // full product width

    // stage 1: coordinate differences
    logic signed [D-1:0] dx1_reg, dy1_reg, dy2_reg, dx2_reg;
    logic signed [D-1:0] dx1_next, dy1_next, dy2_next, dx2_next;

    // stage 2: partial products, index 0 ll, 1 lh, 2 hl, 3 hh
    logic signed [W-1:0] part1_reg [4];
    logic signed [W-1:0] part2_reg [4];
    logic signed [W-1:0] part1_next [4];
    logic signed [W-1:0] part2_next [4];

    // stage 3: full products
    logic signed [P-1:0] prod1_reg, prod2_reg;
    logic signed [P-1:0] prod1_next, prod2_next;

    logic signed [P-1:0] cross_diff;

    function automatic logic signed [M-1:0] lo_slice(input logic signed [D-1:0] v);
        return {1'b0, v[L-1:0]};
    endfunction

    function automatic logic signed [M-1:0] hi_slice(input logic signed [D-1:0] v);
        return {{(M-H){v[D-1]}}, v[D-1:L]};
    endfunction

    function automatic logic signed [P-1:0] widen(input logic signed [W-1:0] v);
        return {{(P-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [P-1:0] join_parts(
        input logic signed [W-1:0] ll,
        input logic signed [W-1:0] lh,
        input logic signed [W-1:0] hl,
        input logic signed [W-1:0] hh
    );
        logic signed [P-1:0] mid;
        mid = widen(lh) + widen(hl);
        return (widen(hh) <<< (2 * L)) + (mid <<< L) + widen(ll);
    endfunction

    always_comb
    begin
        dx1_next = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
        dy1_next = {cy[COORD_BITS-1], cy} - {ay[COORD_BITS-1], ay};
        dy2_next = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
        dx2_next = {cx[COORD_BITS-1], cx} - {ax[COORD_BITS-1], ax};
    end

    // split each operand so every multiplier stays narrow
    always_comb
    begin
        part1_next[0] = lo_slice(dx1_reg) * lo_slice(dy1_reg);
        part1_next[1] = lo_slice(dx1_reg) * hi_slice(dy1_reg);
        part1_next[2] = hi_slice(dx1_reg) * lo_slice(dy1_reg);
        part1_next[3] = hi_slice(dx1_reg) * hi_slice(dy1_reg);
        part2_next[0] = lo_slice(dy2_reg) * lo_slice(dx2_reg);
        part2_next[1] = lo_slice(dy2_reg) * hi_slice(dx2_reg);
        part2_next[2] = hi_slice(dy2_reg) * lo_slice(dx2_reg);
        part2_next[3] = hi_slice(dy2_reg) * hi_slice(dx2_reg);
    end

    always_comb
    begin
        prod1_next = join_parts(part1_reg[0], part1_reg[1], part1_reg[2], part1_reg[3]);
        prod2_next = join_parts(part2_reg[0], part2_reg[1], part2_reg[2], part2_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.en_diff)
        begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            dy2_reg <= dy2_next;
            dx2_reg <= dx2_next;
        end
        if (pipe_en.en_part)
        begin
            part1_reg <= part1_next;
            part2_reg <= part2_next;
        end
        if (pipe_en.en_prod)
        begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    // exact: the difference of the products fits in P bits
    assign cross_diff = prod1_reg - prod2_reg;
    assign sign.neg   = cross_diff[P-1];
    assign sign.zero  = (cross_diff == '0);

endmodule

// File: src/point_in_triangle_classifier.sv
// an accepted query transaction passes the difference, partial, product and result registers before its result is valid
// throughput: one transaction per cycle, sustained while the result side is ready
// the rate is set by the five-stage pipeline: input, differences, split
// products, product sum, sign compare and classification into the result register
// reset (rst_n, async, active low) clears all stage valid bits; data regs hold
// ----------------------------------------------------------------------------
// point_in_triangle_classifier
// classifies a query point against a counter-clockwise triangle as inside,
// on an edge, on a vertex or outside, using three exact orientation tests
// ----------------------------------------------------------------------------
module point_in_triangle_classifier
    import pitc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    pitc_in_if.sink      item,
    pitc_out_if.source   result
);

    // stage 0 input, 1 diff, 2 partials, 3 products, 4 result
    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_en;

    // registered query transaction
    logic signed [COORD_BITS-1:0] v0x_reg, v0y_reg, v1x_reg, v1y_reg;
    logic signed [COORD_BITS-1:0] v2x_reg, v2y_reg, qx_reg, qy_reg;

    containment_t containment_reg;
    containment_t containment_next;

    pipe_en_t     pipe_en;
    orient_sign_t sign_a, sign_b, sign_c;

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || result.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = item.valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            v0x_reg <= item.vertex0_x;
            v0y_reg <= item.vertex0_y;
            v1x_reg <= item.vertex1_x;
            v1y_reg <= item.vertex1_y;
            v2x_reg <= item.vertex2_x;
            v2y_reg <= item.vertex2_y;
            qx_reg  <= item.query_x;
            qy_reg  <= item.query_y;
        end
        if (stage_en[STAGES-1])
        begin
            containment_reg <= containment_next;
        end
    end

    assign pipe_en.en_diff = stage_en[1];
    assign pipe_en.en_part = stage_en[2];
    assign pipe_en.en_prod = stage_en[3];

    // a: orient(v0, v2, p)
    pitc_orient #(.COORD_BITS(COORD_BITS)) u_orient_a (
        .clk     (clk),
        .pipe_en (pipe_en),
        .ax      (v0x_reg),
        .ay      (v0y_reg),
        .bx      (v2x_reg),
        .by      (v2y_reg),
        .cx      (qx_reg),
        .cy      (qy_reg),
        .sign    (sign_a)
    );

    // b: orient(v0, v1, p)
    pitc_orient #(.COORD_BITS(COORD_BITS)) u_orient_b (
        .clk     (clk),
        .pipe_en (pipe_en),
        .ax      (v0x_reg),
        .ay      (v0y_reg),
        .bx      (v1x_reg),
        .by      (v1y_reg),
        .cx      (qx_reg),
        .cy      (qy_reg),
        .sign    (sign_b)
    );

    // c: orient(v2, v1, p)
    pitc_orient #(.COORD_BITS(COORD_BITS)) u_orient_c (
        .clk     (clk),
        .pipe_en (pipe_en),
        .ax      (v2x_reg),
        .ay      (v2y_reg),
        .bx      (v1x_reg),
        .by      (v1y_reg),
        .cx      (qx_reg),
        .cy      (qy_reg),
        .sign    (sign_c)
    );

    // sign cascade, first match wins
    always_comb
    begin
        logic a_neg, a_pos, a_zero;
        logic b_neg, b_pos, b_zero;
        logic c_neg, c_pos, c_zero;
        logic [1:0] zeros;

        a_neg  = sign_a.neg;
        a_zero = sign_a.zero;
        a_pos  = !sign_a.neg && !sign_a.zero;
        b_neg  = sign_b.neg;
        b_zero = sign_b.zero;
        b_pos  = !sign_b.neg && !sign_b.zero;
        c_neg  = sign_c.neg;
        c_zero = sign_c.zero;
        c_pos  = !sign_c.neg && !sign_c.zero;
        zeros  = {1'b0, a_zero} + {1'b0, b_zero} + {1'b0, c_zero};

        if (a_neg && b_pos && c_neg)
        begin
            containment_next = CONT_INSIDE;
        end
        else if (!a_pos && b_pos && c_neg)
        begin
            // point on the edge opposite vertex 1
            containment_next = a_zero ? CONT_EDGE1 : CONT_INSIDE;
        end
        else if (a_neg && !b_neg && c_neg)
        begin
            containment_next = b_zero ? CONT_EDGE2 : CONT_INSIDE;
        end
        else if (a_neg && b_pos && !c_pos)
        begin
            containment_next = c_zero ? CONT_EDGE0 : CONT_INSIDE;
        end
        else if (zeros == 2'd2)
        begin
            // two collinear tests meet at a vertex
            if (a_zero && b_zero)
            begin
                containment_next = CONT_VERTEX0;
            end
            else if (a_zero && c_zero)
            begin
                containment_next = CONT_VERTEX2;
            end
            else
            begin
                containment_next = CONT_VERTEX1;
            end
        end
        else
        begin
            containment_next = CONT_OUTSIDE;
        end
    end

    assign item.ready         = stage_en[0];
    assign result.valid       = valid_reg[STAGES-1];
    assign result.containment = containment_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for point_in_triangle_classifier: directed corner
// cases, then shaped and noise queries, all scored against a local predictor
// of the three orientation tests and the containment cascade
// ----------------------------------------------------------------------------
module tb
    import pitc_pkg::*;
();

    localparam int CB = COORD_BITS_DEF;
    localparam longint COORD_MIN = -(64'sd1 <<< (CB - 1));
    localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
    // far above the slowest legal run of ~700 transactions with worst gaps and stalls
    localparam int CYCLE_LIMIT = 200000;
    // pipeline is five stages deep, drain a few extra cycles on top
    localparam int DRAIN_CYCLES = 16;

    typedef logic signed [CB-1:0] coord_t;

    // one query transaction
    typedef struct {
        coord_t vertex0_x;
        coord_t vertex0_y;
        coord_t vertex1_x;
        coord_t vertex1_y;
        coord_t vertex2_x;
        coord_t vertex2_y;
        coord_t query_x;
        coord_t query_y;
    } query_t;

    logic clk = 1'b0;
    logic rst_n;

    pitc_in_if #(.COORD_BITS(CB)) item_ch();
    pitc_out_if result_ch();

    point_in_triangle_classifier #(
        .COORD_BITS (CB)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // containment codes still owed by the block, oldest first
    containment_t pending_containment[$];

    int fail_count;
    int sent_count;
    int directed_count;
    int checked_count;
    int code_hits[8];
    int cycle_count;
    int burst_left;
    int stall_left;
    int stall_mode;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // sign of (b - a) x (c - a), exact at 128 bits
    function automatic int orient_sign(input longint ax, ay, bx, by, cx, cy);
        logic signed [127:0] ux;
        logic signed [127:0] uy;
        logic signed [127:0] wx;
        logic signed [127:0] wy;
        logic signed [127:0] cross_val;
        ux = bx - ax;
        uy = by - ay;
        wx = cx - ax;
        wy = cy - ay;
        cross_val = ux * wy - uy * wx;
        if (cross_val < 0)
            return -1;
        return (cross_val != 0) ? 1 : 0;
    endfunction

    // three orientation signs run through the containment cascade
    function automatic containment_t predict_containment(input query_t q);
        int sa;
        int sb;
        int sc;
        int zeros;
        containment_t code;
        sa = orient_sign(q.vertex0_x, q.vertex0_y, q.vertex2_x, q.vertex2_y,
                         q.query_x, q.query_y);
        sb = orient_sign(q.vertex0_x, q.vertex0_y, q.vertex1_x, q.vertex1_y,
                         q.query_x, q.query_y);
        sc = orient_sign(q.vertex2_x, q.vertex2_y, q.vertex1_x, q.vertex1_y,
                         q.query_x, q.query_y);
        zeros = (sa == 0) + (sb == 0) + (sc == 0);
        if (sa < 0 && sb > 0 && sc < 0)
            code = CONT_INSIDE;
        else if (sa <= 0 && sb > 0 && sc < 0)
            code = (sa == 0) ? CONT_EDGE1 : CONT_INSIDE;
        else if (sa < 0 && sb >= 0 && sc < 0)
            code = (sb == 0) ? CONT_EDGE2 : CONT_INSIDE;
        else if (sa < 0 && sb > 0 && sc <= 0)
            code = (sc == 0) ? CONT_EDGE0 : CONT_INSIDE;
        else if (zeros == 2)
        begin
            if (sa == 0 && sb == 0)
                code = CONT_VERTEX0;
            else if (sa == 0 && sc == 0)
                code = CONT_VERTEX2;
            else
                code = CONT_VERTEX1;
        end
        else
            code = CONT_OUTSIDE;
        return code;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // uniform value in [-mag, mag], mag up to 2^30
    function automatic longint rand_span(input longint mag);
        return longint'($urandom_range(0, 32'(2 * mag))) - mag;
    endfunction

    function automatic void swap_vertices(ref longint vx[3], ref longint vy[3],
                                          input int i, input int j);
        longint tx;
        longint ty;
        tx = vx[i];
        ty = vy[i];
        vx[i] = vx[j];
        vy[i] = vy[j];
        vx[j] = tx;
        vy[j] = ty;
    endfunction

    function automatic int winding(input longint vx[3], input longint vy[3]);
        return orient_sign(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    endfunction

    function automatic query_t pack_query(input longint vx[3], input longint vy[3],
                                          input longint px, input longint py);
        query_t q;
        q.vertex0_x = coord_t'(vx[0]);
        q.vertex0_y = coord_t'(vy[0]);
        q.vertex1_x = coord_t'(vx[1]);
        q.vertex1_y = coord_t'(vy[1]);
        q.vertex2_x = coord_t'(vx[2]);
        q.vertex2_y = coord_t'(vy[2]);
        q.query_x   = coord_t'(px);
        q.query_y   = coord_t'(py);
        return q;
    endfunction

    // well-formed triangle plus a point placed on purpose: inside, on an
    // edge, on a vertex, near the boundary, outside, or against a degenerate
    // or clockwise triangle; edge AB is an exact lattice segment so points
    // on it are exactly collinear
    function automatic query_t make_placement();
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint px, py, dmag, off;
        longint vx[3];
        longint vy[3];
        int hi_m, m, k, kind, e, i1, i2, wa, wb, wc;
        case ($urandom_range(0, 3))
            0:       begin dmag = 3;     hi_m = 8;     end
            1:       begin dmag = 15;    hi_m = 64;    end
            2:       begin dmag = 1023;  hi_m = 1023;  end
            default: begin dmag = 65535; hi_m = 16383; end
        endcase
        off = dmag * hi_m;
        ax = rand_span(64'sd1 << 29);
        ay = rand_span(64'sd1 << 29);
        dx = rand_span(dmag);
        dy = rand_span(dmag);
        m  = $urandom_range(2, hi_m);
        k  = $urandom_range(1, m - 1);
        bx = ax + m * dx;
        by = ay + m * dy;
        cx = ax + rand_span(off);
        cy = ay + rand_span(off);
        // point strictly between A and B on the lattice segment
        px = ax + k * dx;
        py = ay + k * dy;
        vx = '{ax, bx, cx};
        vy = '{ay, by, cy};
        wa = $urandom_range(1, 16);
        wb = $urandom_range(1, 16);
        wc = $urandom_range(1, 16);
        kind = $urandom_range(0, 9);
        case (kind)
            2, 3, 4:
            begin
                // edge e lies opposite vertex e
                e  = kind - 2;
                i1 = (e == 0) ? 1 : 0;
                i2 = (e == 2) ? 1 : 2;
                vx[e]  = cx;
                vy[e]  = cy;
                vx[i1] = ax;
                vy[i1] = ay;
                vx[i2] = bx;
                vy[i2] = by;
                if (winding(vx, vy) < 0)
                    swap_vertices(vx, vy, i1, i2);
            end
            5:
            begin
                if (winding(vx, vy) < 0)
                    swap_vertices(vx, vy, 1, 2);
                k  = $urandom_range(0, 2);
                px = vx[k];
                py = vy[k];
            end
            6:
            begin
                // collinear vertices, point on the line or anywhere near
                vx[1] = ax + $urandom_range(0, hi_m) * dx;
                vy[1] = ay + $urandom_range(0, hi_m) * dy;
                vx[2] = ax + $urandom_range(0, hi_m) * dx;
                vy[2] = ay + $urandom_range(0, hi_m) * dy;
                if ($urandom_range(0, 1))
                begin
                    px = ax + $urandom_range(0, hi_m) * dx;
                    py = ay + $urandom_range(0, hi_m) * dy;
                end
                else
                begin
                    px = ax + rand_span(off);
                    py = ay + rand_span(off);
                end
            end
            7:
            begin
                // clockwise winding on purpose
                if (winding(vx, vy) > 0)
                    swap_vertices(vx, vy, 1, 2);
                if ($urandom_range(0, 1))
                begin
                    px = (wa * vx[0] + wb * vx[1] + wc * vx[2]) / (wa + wb + wc);
                    py = (wa * vy[0] + wb * vy[1] + wc * vy[2]) / (wa + wb + wc);
                end
            end
            8:
            begin
                if (winding(vx, vy) < 0)
                    swap_vertices(vx, vy, 1, 2);
                px = cx + rand_span(off);
                py = cy + rand_span(off);
            end
            9:
            begin
                // just off edge AB, either side
                if (winding(vx, vy) < 0)
                    swap_vertices(vx, vy, 0, 1);
                px = px + rand_span(2);
                py = py + rand_span(2);
            end
            default:
            begin
                if (winding(vx, vy) < 0)
                    swap_vertices(vx, vy, 1, 2);
                px = (wa * vx[0] + wb * vx[1] + wc * vx[2]) / (wa + wb + wc);
                py = (wa * vy[0] + wb * vy[1] + wc * vy[2]) / (wa + wb + wc);
            end
        endcase
        return pack_query(vx, vy, px, py);
    endfunction

    // one field of a noise transaction: mostly raw bits, some extremes
    function automatic coord_t noise_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(COORD_MIN);
            1:       return coord_t'(COORD_MAX);
            2:       return coord_t'(rand_span(4));
            default: return coord_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    task automatic send_query(input query_t q);
        containment_t code;
        @(negedge clk);
        if (burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_ch.vertex0_x <= q.vertex0_x;
        item_ch.vertex0_y <= q.vertex0_y;
        item_ch.vertex1_x <= q.vertex1_x;
        item_ch.vertex1_y <= q.vertex1_y;
        item_ch.vertex2_x <= q.vertex2_x;
        item_ch.vertex2_y <= q.vertex2_y;
        item_ch.query_x   <= q.query_x;
        item_ch.query_y   <= q.query_y;
        item_ch.valid     <= 1'b1;
        // hold until the transaction is taken
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        code = predict_containment(q);
        pending_containment.push_back(code);
        code_hits[code]++;
        sent_count++;
    endtask

    task automatic send_coords(input longint x0, y0, x1, y1, x2, y2, px, py);
        longint vx[3];
        longint vy[3];
        vx = '{x0, x1, x2};
        vy = '{y0, y1, y2};
        send_query(pack_query(vx, vy, px, py));
        directed_count++;
    endtask

    // ------------------------------------------------------------------------
    // result side: stall pattern of its own, changes mode every stretch
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= $urandom_range(0, 1);
            2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
            default: result_ch.ready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // checker: every accepted result against the oldest pending code
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_containment.size() == 0)
            begin
                $error("containment: result with no query pending, actual %0d",
                       result_ch.containment);
                fail_count++;
            end
            else
            begin
                if (result_ch.containment !== pending_containment[0])
                begin
                    $error("containment mismatch: expected %0d (%s), actual %0d",
                           pending_containment[0], pending_containment[0].name(),
                           result_ch.containment);
                    fail_count++;
                end
                void'(pending_containment.pop_front());
                checked_count++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[point_in_triangle_classifier] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // full-width corners, including bit patterns beyond the nominal range
    task automatic test_extreme_coordinates();
        longint lo;
        longint hi;
        longint rl;
        longint rh;
        lo = COORD_MIN;
        hi = COORD_MAX;
        rl = -1800000000;
        rh = 1800000000;
        // every vertex and the point coincide: all three signs zero
        send_coords(lo, lo, lo, lo, lo, lo, lo, lo);
        send_coords(hi, hi, hi, hi, hi, hi, hi, hi);
        // largest triangle, hypotenuse on x + y = -1
        send_coords(lo, lo, hi, lo, lo, hi, hi, hi);
        send_coords(lo, lo, hi, lo, lo, hi, lo, lo);
        send_coords(lo, lo, hi, lo, lo, hi, hi, lo);
        send_coords(lo, lo, hi, lo, lo, hi, lo, hi);
        send_coords(lo, lo, hi, lo, lo, hi, 0, -1);
        send_coords(lo, lo, hi, lo, lo, hi, lo, 0);
        send_coords(lo, lo, hi, lo, lo, hi, 0, lo);
        send_coords(lo, lo, hi, lo, lo, hi, -1, -1);
        // nominal range limits, point on the right-hand edge
        send_coords(rl, rl, rh, rl, rh, rh, rh, 0);
    endtask

    // inside, every edge code, vertex 1 and outside on a small right triangle
    task automatic test_small_triangle_cases();
        send_coords(0, 0, 10, 0, 0, 10, 2, 3);
        send_coords(0, 0, 10, 0, 0, 10, 5, 5);
        send_coords(0, 0, 10, 0, 0, 10, 0, 4);
        send_coords(0, 0, 10, 0, 0, 10, 6, 0);
        send_coords(0, 0, 10, 0, 0, 10, 10, 0);
        send_coords(0, 0, 10, 0, 0, 10, 11, 11);
        send_coords(0, 0, 10, 0, 0, 10, -1, 5);
    endtask

    // collinear vertices and clockwise winding go through the cascade unchanged
    task automatic test_degenerate_and_clockwise();
        send_coords(7, -7, 7, -7, 7, -7, 7, -7);
        send_coords(0, 0, 5, 5, 10, 10, 3, 3);
        send_coords(0, 0, 5, 5, 10, 10, 3, 4);
        send_coords(0, 0, 0, 10, 10, 0, 2, 3);
        send_coords(0, 0, 0, 10, 10, 0, 5, 5);
    endtask

    // well-formed triangles with points placed on purpose
    task automatic test_random_placement(input int count);
        repeat (count)
            send_query(make_placement());
    endtask

    // arbitrary bit patterns in every field
    task automatic test_random_noise(input int count);
        query_t q;
        repeat (count)
        begin
            q.vertex0_x = noise_coord();
            q.vertex0_y = noise_coord();
            q.vertex1_x = noise_coord();
            q.vertex1_y = noise_coord();
            q.vertex2_x = noise_coord();
            q.vertex2_y = noise_coord();
            q.query_x   = noise_coord();
            q.query_y   = noise_coord();
            send_query(q);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.vertex0_x  = '0;
        item_ch.vertex0_y  = '0;
        item_ch.vertex1_x  = '0;
        item_ch.vertex1_y  = '0;
        item_ch.vertex2_x  = '0;
        item_ch.vertex2_y  = '0;
        item_ch.query_x    = '0;
        item_ch.query_y    = '0;
        result_ch.ready    = 1'b0;
        fail_count         = 0;
        sent_count         = 0;
        directed_count     = 0;
        checked_count      = 0;
        cycle_count        = 0;
        burst_left         = 0;
        stall_left         = 0;
        stall_mode         = 0;
        code_hits          = '{default: 0};

        // reset held low at start, released away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_coordinates();
        test_small_triangle_cases();
        test_degenerate_and_clockwise();
        test_random_placement(520);
        test_random_noise(130);

        @(negedge clk);
        item_ch.valid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (pending_containment.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d query transactions (%0d directed), checked %0d results",
                 sent_count, directed_count, checked_count);
        $display("codes: inside %0d, edge %0d/%0d/%0d, vertex %0d/%0d/%0d, outside %0d",
                 code_hits[CONT_INSIDE], code_hits[CONT_EDGE0], code_hits[CONT_EDGE1],
                 code_hits[CONT_EDGE2], code_hits[CONT_VERTEX0], code_hits[CONT_VERTEX1],
                 code_hits[CONT_VERTEX2], code_hits[CONT_OUTSIDE]);
        if (fail_count == 0)
            $display("[point_in_triangle_classifier] OK");
        else
            $display("[point_in_triangle_classifier] ERROR");
        $finish;
    end

endmodule

// File: point_in_triangle_classifier.f
src/pitc_pkg.sv
src/pitc_if.sv
src/pitc_orient.sv
src/point_in_triangle_classifier.sv
tb/tb.sv
